@@ src/wvm_pkg.sv @@
package wvm_pkg;

	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int PHASE_FRAC_BITS_DEF = 12;
	localparam int VOLUME_SHIFT_DEF    = 8;

	localparam logic [3:0] TABLE_SIZE_LOG2_RST = 4'd10;

	localparam logic [1:0] OP_MIX       = 2'd0;
	localparam logic [1:0] OP_WRITE     = 2'd1;
	localparam logic [1:0] OP_SET_PHASE = 2'd2;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [9:0]          table_address;
		logic signed [15:0]  table_data;
		logic [31:0]         phase_value;
		logic [31:0]         phase_step;
		logic [7:0]          volume;
		logic signed [31:0]  mix_in;
		logic                last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0]  mix_out;
		logic                last_out;
	} out_item_t;

	typedef struct packed {
		logic [7:0]          volume;
		logic signed [31:0]  mix_in;
		logic                last_in;
	} mix_side_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} stage_hs_t;

endpackage

@@ src/wvm_ram.sv @@
module wvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/wvm_mix.sv @@
module wvm_mix #(
	parameter int SAMPLE_WIDTH = wvm_pkg::SAMPLE_WIDTH_DEF,
	parameter int VOLUME_SHIFT = wvm_pkg::VOLUME_SHIFT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s1_valid,
	output logic                    s1_ready,
	input  logic [SAMPLE_WIDTH-1:0] sample_s1,
	input  wvm_pkg::mix_side_t      side_s1,
	output logic                    out_valid,
	input  logic                    out_ready,
	output wvm_pkg::out_item_t      out_data
);

	localparam int PW = SAMPLE_WIDTH + 9;

	logic                 v_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [31:0]   mix_s2;
	logic                 last_s2;
	logic                 en_out;
	logic                 en_s2;
	logic signed [PW-1:0] prod;
	logic signed [63:0]   prod_ext;
	logic signed [63:0]   prod_shr;
	wvm_pkg::stage_hs_t   out_hs;

	assign en_out   = !out_valid || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign s1_ready = en_s2;

	assign prod     = $signed(sample_s1) * $signed({1'b0, side_s1.volume});
	assign prod_ext = {{(64-PW){prod_s2[PW-1]}}, prod_s2};
	assign prod_shr = prod_ext >>> VOLUME_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= s1_valid;
			end
			if (en_out) begin
				out_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && s1_valid) begin
			prod_s2 <= prod;
			mix_s2  <= side_s1.mix_in;
			last_s2 <= side_s1.last_in;
		end
		if (en_out && v_s2) begin
			out_data.mix_out  <= mix_s2 + prod_shr[31:0];
			out_data.last_out <= last_s2;
		end
	end

	assign out_hs = '{valid: out_valid, ready: out_ready};

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && out_hs.valid && !out_hs.ready |=> v_s2 && $stable(prod_s2) && $stable(mix_s2))
		else $error("stalled s2 beat changed");

	a_no_s1_loss: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_ready |-> v_s2 && out_valid && !out_ready)
		else $error("s1 stalled without full downstream");

endmodule

@@ src/wavetable_voice_mixer_core.sv @@
// Channel  Handshake                  Payload                      Dir
// in       in_valid / in_ready        in_data  (wvm_pkg::in_item_t)  in
// out      out_valid / out_ready      out_data (wvm_pkg::out_item_t) out
// cfg      cfg_wr_en                  cfg_wr_data (table_size_log2)  in
//
// One beat per cycle sustained while the output is not stalled; a mix beat reaches out_data
// after the table RAM read at acceptance, product register and shift-add output register.
// Write and set-phase beats finish at acceptance and give no output.
// Reset clears the phase to zero and table_size_log2 to 10; table contents are not cleared.
// Output stalls back up through two internal stages before in_ready drops.
module wavetable_voice_mixer_core #(
	parameter int TABLE_ADDR_BITS = wvm_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_WIDTH    = wvm_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_FRAC_BITS = wvm_pkg::PHASE_FRAC_BITS_DEF,
	parameter int VOLUME_SHIFT    = wvm_pkg::VOLUME_SHIFT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wvm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wvm_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_wr_data
);

	logic [3:0]                   size_log2_q;
	logic [31:0]                  phase_q;
	logic                         v_s1;
	wvm_pkg::mix_side_t           side_s1;
	logic                         s1_ready;
	logic                         en_s1;
	logic                         accept;
	logic                         is_mix;
	logic [31:0]                  phase_int;
	logic [TABLE_ADDR_BITS-1:0]   idx_mask;
	logic [TABLE_ADDR_BITS-1:0]   rd_idx;
	logic [TABLE_ADDR_BITS+9:0]   wa_ext;
	logic [SAMPLE_WIDTH+15:0]     wd_ext;
	logic [SAMPLE_WIDTH-1:0]      rd_data;

	assign accept   = in_valid && in_ready;
	assign is_mix   = in_data.opcode == wvm_pkg::OP_MIX;
	assign en_s1    = !v_s1 || s1_ready;
	assign in_ready = en_s1;

	assign phase_int = phase_q >> PHASE_FRAC_BITS;

	always_comb begin
		for (int i = 0; i < TABLE_ADDR_BITS; i++) begin
			idx_mask[i] = {28'd0, size_log2_q} > 32'(i);
		end
	end

	assign rd_idx = phase_int[TABLE_ADDR_BITS-1:0] & idx_mask;
	assign wa_ext = {{TABLE_ADDR_BITS{1'b0}}, in_data.table_address};
	assign wd_ext = {{SAMPLE_WIDTH{in_data.table_data[15]}}, in_data.table_data};

	wvm_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(1 << TABLE_ADDR_BITS)
	) u_table (
		.clk   (clk),
		.we    (accept && in_data.opcode == wvm_pkg::OP_WRITE),
		.waddr (wa_ext[TABLE_ADDR_BITS-1:0]),
		.wdata (wd_ext[SAMPLE_WIDTH-1:0]),
		.re    (accept && is_mix),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= wvm_pkg::TABLE_SIZE_LOG2_RST;
			phase_q     <= '0;
			v_s1        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_log2_q <= cfg_wr_data;
			end
			if (accept) begin
				case (in_data.opcode)
					wvm_pkg::OP_MIX:       phase_q <= phase_q + in_data.phase_step;
					wvm_pkg::OP_SET_PHASE: phase_q <= in_data.phase_value;
					default:               phase_q <= phase_q;
				endcase
			end
			if (en_s1) begin
				v_s1 <= accept && is_mix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_mix) begin
			side_s1.volume  <= in_data.volume;
			side_s1.mix_in  <= in_data.mix_in;
			side_s1.last_in <= in_data.last_in;
		end
	end

	wvm_mix #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.VOLUME_SHIFT (VOLUME_SHIFT)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (v_s1),
		.s1_ready  (s1_ready),
		.sample_s1 (rd_data),
		.side_s1   (side_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_ready |=> $stable(rd_data))
		else $error("table read data lost under stall");

	a_set_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.opcode == wvm_pkg::OP_SET_PHASE
		|=> phase_q == $past(in_data.phase_value))
		else $error("phase load missed");

	a_idx_masked: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_mix |-> (rd_idx & ~idx_mask) == '0)
		else $error("table index outside size in use");

endmodule

@@ test/tb_wavetable_voice_mixer_core.sv @@
`timescale 1ns / 1ps

module tb_wavetable_voice_mixer_core;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int TABLE_DEPTH = 1 << wvm_pkg::TABLE_ADDR_BITS_DEF;
	localparam int SEG_COUNT = 9;
	localparam int SEG_BEATS = 210;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		wvm_pkg::in_item_t  beat;
		logic               typed;
		wvm_pkg::out_item_t want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	wvm_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	wvm_pkg::out_item_t out_data;
	logic               cfg_wr_en;
	logic [3:0]         cfg_wr_data;

	logic signed [15:0] voice_table [TABLE_DEPTH];
	bit                 entry_loaded [TABLE_DEPTH];
	logic [31:0]        voice_phase;
	logic [3:0]         size_log2;
	wvm_pkg::out_item_t pending_mix [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_asks;
	int fails;
	int cycles;

	dir_row_t dir_rows [16] = '{
		'{'{wvm_pkg::OP_WRITE, 10'd0, 16'sh7FFF, 32'h0, 32'h0, 8'd0, 32'h0, 1'b0},
			1'b0, '0},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h0, 8'd0, 32'h7FFFFFFF, 1'b1},
			1'b1, '{32'h7FFFFFFF, 1'b1}},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h0, 8'd255, 32'h0, 1'b0},
			1'b0, '0},
		'{'{wvm_pkg::OP_WRITE, 10'd1023, 16'sh8000, 32'h0, 32'h0, 8'd0, 32'h0, 1'b0},
			1'b0, '0},
		'{'{wvm_pkg::OP_SET_PHASE, 10'd0, 16'sd0, 32'hFFFFFFFF, 32'h0, 8'd0, 32'h0,
			1'b0}, 1'b0, '0},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h00001000, 8'd255, 32'h80000000,
			1'b1}, 1'b0, '0},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h0, 8'd1, 32'h0, 1'b0},
			1'b0, '0},
		'{'{wvm_pkg::OP_WRITE, 10'd1, 16'shFFFF, 32'h0, 32'h0, 8'd0, 32'h0, 1'b0},
			1'b0, '0},
		'{'{wvm_pkg::OP_SET_PHASE, 10'd0, 16'sd0, 32'h00001000, 32'h0, 8'd0, 32'h0,
			1'b0}, 1'b0, '0},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'hFFFFF000, 8'd1, 32'h0, 1'b0},
			1'b0, '0},
		'{'{OP_UNUSED, 10'h3FF, 16'shFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'h7FFFFFFF,
			1'b1}, 1'b0, '0},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h0, 8'd128, 32'h7FFFFFFF, 1'b1},
			1'b0, '0},
		'{'{wvm_pkg::OP_WRITE, 10'd2, 16'sd0, 32'h0, 32'h0, 8'd255, 32'hFFFFFFFF, 1'b1},
			1'b0, '0},
		'{'{wvm_pkg::OP_SET_PHASE, 10'd0, 16'sd0, 32'h00002ABC, 32'hFFFFFFFF, 8'd255,
			32'hFFFFFFFF, 1'b1}, 1'b0, '0},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h0, 8'd255, 32'h12345678, 1'b0},
			1'b1, '{32'h12345678, 1'b0}},
		'{'{wvm_pkg::OP_MIX, 10'd0, 16'sd0, 32'h0, 32'h0, 8'd255, 32'h80000000, 1'b1},
			1'b1, '{32'h80000000, 1'b1}}
	};

	logic [3:0] seg_sizes [SEG_COUNT] = '{4'd0, 4'd15, 4'd10, 4'd3, 4'd11, 4'd1, 4'd7,
		4'd10, 4'd5};

	wavetable_voice_mixer_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [9:0] table_index(logic [31:0] ph);
		logic [3:0] lg;
		lg = (size_log2 > wvm_pkg::TABLE_ADDR_BITS_DEF) ?
			4'(wvm_pkg::TABLE_ADDR_BITS_DEF) : size_log2;
		return 10'((ph >> wvm_pkg::PHASE_FRAC_BITS_DEF) & ((32'd1 << lg) - 32'd1));
	endfunction

	function automatic void advance_voice(wvm_pkg::in_item_t b, logic typed,
		wvm_pkg::out_item_t want);
		logic [9:0]         idx;
		longint             prod;
		wvm_pkg::out_item_t res;
		case (b.opcode)
			wvm_pkg::OP_WRITE: begin
				voice_table[b.table_address] = b.table_data;
				entry_loaded[b.table_address] = 1'b1;
			end
			wvm_pkg::OP_SET_PHASE: begin
				voice_phase = b.phase_value;
			end
			wvm_pkg::OP_MIX: begin
				idx = table_index(voice_phase);
				prod = (longint'(voice_table[idx]) * longint'(b.volume))
					>>> wvm_pkg::VOLUME_SHIFT_DEF;
				res.mix_out = b.mix_in + prod[31:0];
				res.last_out = b.last_in;
				pending_mix.push_back(typed ? want : res);
				voice_phase = voice_phase + b.phase_step;
			end
			default: ;
		endcase
	endfunction

	function automatic wvm_pkg::in_item_t random_beat(logic [1:0] op);
		wvm_pkg::in_item_t b;
		b.opcode = op;
		b.table_address = 10'($urandom_range(0, TABLE_DEPTH - 1));
		case ($urandom_range(0, 7))
			0: b.table_data = 16'sh8000;
			1: b.table_data = 16'sh7FFF;
			default: b.table_data = 16'($urandom());
		endcase
		b.phase_value = $urandom();
		case ($urandom_range(0, 5))
			0: b.phase_step = 32'h0;
			1: b.phase_step = 32'hFFFFFFFF;
			2, 3: b.phase_step = $urandom_range(0, 32'h00020000);
			default: b.phase_step = $urandom();
		endcase
		case ($urandom_range(0, 5))
			0: b.volume = 8'd0;
			1: b.volume = 8'd255;
			default: b.volume = 8'($urandom());
		endcase
		case ($urandom_range(0, 7))
			0: b.mix_in = 32'h80000000;
			1: b.mix_in = 32'h7FFFFFFF;
			default: b.mix_in = $urandom();
		endcase
		b.last_in = 1'($urandom_range(0, 1));
		return b;
	endfunction

	task automatic push_beat(wvm_pkg::in_item_t b, logic typed, wvm_pkg::out_item_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		advance_voice(b, typed, want);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_mix.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_table_size(logic [3:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		size_log2 = v;
		@(posedge clk);
	endtask

	initial begin : rx
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (served != hold_asks) begin
				served = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		wvm_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_mix.size() == 0) begin
				$error("mix beat with nothing pending: mix_out %h last_out %b",
					out_data.mix_out, out_data.last_out);
				fails++;
			end else begin
				want = pending_mix.pop_front();
				if (out_data.mix_out !== want.mix_out) begin
					$error("mix_out: expected %h, got %h", want.mix_out, out_data.mix_out);
					fails++;
				end
				if (out_data.last_out !== want.last_out) begin
					$error("last_out: expected %b, got %b", want.last_out, out_data.last_out);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [1:0]        op;
		logic [9:0]        idx;
		wvm_pkg::in_item_t b;
		wvm_pkg::in_item_t w;
		int                n;
		int                pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 4'd0;
		voice_phase = 32'h0;
		size_log2 = wvm_pkg::TABLE_SIZE_LOG2_RST;
		hold_asks = 0;
		fails = 0;
		cycles = 0;
		send_idle_pct = 36;
		recv_idle_pct = 65;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		for (int s = 0; s < SEG_COUNT; s++) begin
			set_table_size(seg_sizes[s]);
			send_idle_pct = (s < 3) ? 36 : (s < 6) ? 65 : 0;
			recv_idle_pct = (s < 3) ? 65 : (s < 6) ? 36 : 0;
			if (s == 6)
				hold_asks++;
			n = 0;
			while (n < SEG_BEATS) begin
				pick = $urandom_range(0, 99);
				op = (pick < 55) ? wvm_pkg::OP_MIX : (pick < 75) ? wvm_pkg::OP_WRITE :
					(pick < 90) ? wvm_pkg::OP_SET_PHASE : OP_UNUSED;
				b = random_beat(op);
				if (op == wvm_pkg::OP_MIX) begin
					idx = table_index(voice_phase);
					if (!entry_loaded[idx]) begin
						w = random_beat(wvm_pkg::OP_WRITE);
						w.table_address = idx;
						push_beat(w, 1'b0, '0);
						n++;
					end
				end
				push_beat(b, 1'b0, '0);
				if (op != OP_UNUSED)
					n++;
			end
		end

		wait_drained();
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ wavetable_voice_mixer_core.f @@
src/wvm_pkg.sv
src/wvm_ram.sv
src/wvm_mix.sv
src/wavetable_voice_mixer_core.sv
test/tb_wavetable_voice_mixer_core.sv
